/* rtl/core/gray_to_feed_rate_mapper_defines.svh */
// ---------------------------------------------------------------------------
// Gray to feed rate mapper assertion macros
// Concurrent assertion wrappers that compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef GRAY_TO_FEED_RATE_MAPPER_DEFINES_SVH
`define GRAY_TO_FEED_RATE_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS
`define GTFR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gtfr assertion failed");
`define GTFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gtfr assertion failed");
`else
`define GTFR_ASSERT_SAME(label, ante, cons)
`define GTFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/gtfr_pkg.sv */
// ---------------------------------------------------------------------------
// Gray to feed rate mapper package
// Shared widths, register indexes, mode codes and the divider stage type.
// ---------------------------------------------------------------------------
package gtfr_pkg;

    localparam int RATE_W      = 16;
    localparam int GRAY_W      = 8;
    localparam int TAB_ENTRIES = 17;
    localparam int TAB_AW      = 5;
    localparam int NUM_W       = 56;
    localparam int DEN_W       = 32;
    localparam int QUO_W       = 17;
    localparam int CFG_AW      = 2;

    localparam logic [CFG_AW-1:0] REG_SPEED_MODE  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_BLACK_SPEED = 2'd1;
    localparam logic [CFG_AW-1:0] REG_WHITE_SPEED = 2'd2;
    localparam logic [CFG_AW-1:0] REG_CURVE_GAIN  = 2'd3;

    localparam logic [1:0] MODE_LINEAR    = 2'd0;
    localparam logic [1:0] MODE_PARABOLIC = 2'd1;

    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef struct packed {
        logic              vld;
        logic [NUM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [QUO_W-1:0]  quo;
        logic              ovf;
        logic              zdiv;
        logic [RATE_W:0]   tab;
    } t_div;

endpackage

/* rtl/core/gtfr_div.sv */
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, with an overflow check for quotients too wide.
// ---------------------------------------------------------------------------
module gtfr_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  gtfr_pkg::t_div i_stage,
    output gtfr_pkg::t_div o_stage
);
    import gtfr_pkg::*;

    t_div r_st [0:QUO_W];
    t_div n_st [0:QUO_W];

    always_comb begin
        n_st[0]     = i_stage;
        n_st[0].quo = '0;
        n_st[0].ovf = i_stage.rem >= ({{(NUM_W-DEN_W){1'b0}}, i_stage.den} << QUO_W);
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [NUM_W-1:0] w_sub;
        assign w_sub = {{(NUM_W-DEN_W){1'b0}}, r_st[k].den} << (QUO_W-1-k);
        always_comb begin
            n_st[k+1] = r_st[k];
            if (r_st[k].rem >= w_sub) begin
                n_st[k+1].rem = r_st[k].rem - w_sub;
                n_st[k+1].quo[QUO_W-1-k] = 1'b1;
            end
        end
    end

    for (genvar s = 0; s <= QUO_W; s++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[s].vld <= 1'b0;
            end else if (i_en) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_stage = r_st[QUO_W];

endmodule

/* rtl/core/gray_to_feed_rate_mapper.sv */
// ---------------------------------------------------------------------------
// Gray to feed rate mapper
// Maps 8-bit gray levels to feed rates by a linear, parabolic or table curve.
// ---------------------------------------------------------------------------
// An input transfer either converts a gray level or writes one rate table
// entry. Only a conversion makes an output transfer; a table write makes none.
// Both channels use valid and stall; a transfer happens when valid is high and
// stall is low. Configuration is written over a separate valid/ready port that
// is always ready; the user must write it only while no conversion is in
// flight, and the block does not enforce this. A conversion can enter every
// cycle while the output is not stalled. The pipeline depth is set by a
// 17-stage restoring divider that yields one quotient bit per stage behind
// one overflow check stage, plus three stages of table read and multiplies,
// the divider input, and the output register.
// When the receiver stalls a valid result, the whole pipeline holds and the
// input stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and the configuration registers. The rate table
// is not cleared and must be written before table mode reads it.
// Results above 65535, and parabolic mode with black speed below 2, return
// 65535 with the saturated flag set.
// ---------------------------------------------------------------------------
`include "gray_to_feed_rate_mapper_defines.svh"

module gray_to_feed_rate_mapper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [gtfr_pkg::GRAY_W-1:0]   i_gray,
    input  logic [gtfr_pkg::TAB_AW-1:0]   i_entry_index,
    input  logic [gtfr_pkg::RATE_W-1:0]   i_entry_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gtfr_pkg::RATE_W-1:0]   o_feed_rate,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gtfr_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [gtfr_pkg::RATE_W-1:0]   i_cfg_data
);
    import gtfr_pkg::*;

    logic [1:0]        r_mode;
    logic [RATE_W-1:0] r_black;
    logic [RATE_W-1:0] r_white;
    logic [RATE_W-1:0] r_gain;

    logic [RATE_W-1:0] r_tab_lo [0:TAB_ENTRIES-1];
    logic [RATE_W-1:0] r_tab_hi [0:TAB_ENTRIES-1];

    logic w_en;
    logic w_accept;

    logic              r1_vld;
    logic [GRAY_W-1:0] r1_gray;
    logic [RATE_W-1:0] r1_lo;
    logic [RATE_W-1:0] r1_hi;

    logic              r2_vld;
    logic [12:0]       r2_bd10;
    logic [23:0]       r2_gk;
    logic [23:0]       r2_lin;
    logic [RATE_W:0]   r2_tab;
    logic [8:0]        r2_g300;

    logic              r3_vld;
    logic [31:0]       r3_bsq;
    logic [23:0]       r3_gk;
    logic [23:0]       r3_lin;
    logic [RATE_W:0]   r3_tab;
    logic [23:0]       r3_den;

    t_div r4_div;
    t_div n4_div;
    t_div w_div_out;

    logic              r_out_vld;
    logic [RATE_W-1:0] r_feed;
    logic              r_sat;
    logic [RATE_W-1:0] n_feed;
    logic              n_sat;

    logic [RATE_W-1:0] w_diff;
    logic [RATE_W-1:0] w_tdiff;
    logic [31:0]       w_b10p;
    logic [RATE_W-1:0] w_base;
    logic [RATE_W-2:0] w_half;
    logic [17:0]       w_sum;

    assign w_en        = !r_out_vld || !i_stall;
    assign o_stall     = !w_en;
    assign w_accept    = i_valid && w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LINEAR;
            r_black <= '0;
            r_white <= '0;
            r_gain  <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SPEED_MODE:  r_mode  <= i_cfg_data[1:0];
                REG_BLACK_SPEED: r_black <= i_cfg_data;
                REG_WHITE_SPEED: r_white <= i_cfg_data;
                REG_CURVE_GAIN:  r_gain  <= i_cfg_data;
                default:         r_mode  <= r_mode;
            endcase
        end
    end

    // Two copies of the table so that both interpolation points read at once.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_req_type && (i_entry_index < TAB_AW'(TAB_ENTRIES))) begin
            r_tab_lo[i_entry_index] <= i_entry_value;
            r_tab_hi[i_entry_index] <= i_entry_value;
        end
        if (w_en) begin
            r1_lo   <= r_tab_lo[{1'b0, i_gray[7:4]}];
            r1_hi   <= r_tab_hi[{1'b0, i_gray[7:4]} + TAB_AW'(1)];
            r1_gray <= i_gray;
        end
    end

    assign w_diff  = (r_white >= r_black) ? (r_white - r_black) : (r_black - r_white);
    assign w_tdiff = (r1_hi >= r1_lo) ? (r1_hi - r1_lo) : (r1_lo - r1_hi);
    assign w_b10p  = 32'(r_black) * 32'd52429;
    assign w_base  = r_black - {3'b0, r2_bd10};
    assign w_half  = r_black[RATE_W-1:1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_bd10 <= w_b10p[31:19];
            r2_gk   <= 24'(r1_gray) * 24'(r_gain);
            r2_lin  <= 24'(w_diff) * 24'(r1_gray);
            r2_tab  <= {1'b0, r1_lo} + 17'((20'(w_tdiff) * 20'(r1_gray[3:0])) >> 4);
            r2_g300 <= 9'd300 - 9'(r1_gray);
            r3_bsq  <= 32'(w_base) * 32'(w_base);
            r3_gk   <= r2_gk;
            r3_lin  <= r2_lin;
            r3_tab  <= r2_tab;
            r3_den  <= 24'(w_half) * 24'(r2_g300);
        end
    end

    always_comb begin
        n4_div      = '0;
        n4_div.vld  = r3_vld;
        n4_div.tab  = r3_tab;
        n4_div.zdiv = (w_half == '0);
        if (r_mode == MODE_PARABOLIC) begin
            n4_div.rem = NUM_W'(r3_bsq) * NUM_W'(r3_gk);
            n4_div.den = {r3_den, 8'b0};
        end else begin
            n4_div.rem = NUM_W'(r3_lin);
            n4_div.den = DEN_W'(255);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld     <= 1'b0;
            r2_vld     <= 1'b0;
            r3_vld     <= 1'b0;
            r4_div.vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= w_accept && !i_req_type;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_div <= n4_div;
        end
    end

    gtfr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_stage (r4_div),
        .o_stage (w_div_out)
    );

    assign w_sum = {2'b0, r_black} + {1'b0, w_div_out.quo};

    always_comb begin
        n_sat  = 1'b0;
        n_feed = w_div_out.tab[RATE_W-1:0];
        case (r_mode)
            MODE_LINEAR: begin
                n_feed = (r_white >= r_black) ? (r_black + w_div_out.quo[RATE_W-1:0])
                                              : (r_black - w_div_out.quo[RATE_W-1:0]);
            end
            MODE_PARABOLIC: begin
                if (w_div_out.zdiv || w_div_out.ovf || (w_sum[17:16] != 2'b0)) begin
                    n_feed = RATE_MAX;
                    n_sat  = 1'b1;
                end else begin
                    n_feed = w_sum[RATE_W-1:0];
                end
            end
            default: begin
                if (w_div_out.tab[RATE_W]) begin
                    n_feed = RATE_MAX;
                    n_sat  = 1'b1;
                end else begin
                    n_feed = w_div_out.tab[RATE_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_div_out.vld;
            r_feed    <= n_feed;
            r_sat     <= n_sat;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_feed_rate = r_feed;
    assign o_saturated = r_sat;

    `GTFR_ASSERT_SAME(a_sat_max, o_valid && o_saturated, o_feed_rate == RATE_MAX)
    `GTFR_ASSERT_SAME(a_stall_only_full, o_stall, o_valid)
    `GTFR_ASSERT_NEXT(a_write_no_result, w_accept && i_req_type, !r1_vld)

endmodule
